// ----- rtl/crc8fa_pkg.sv -----
// ----------------------------------------------------------------------------
// crc8fa_pkg: shared types and constants of the crc-8 frame appender
// result record, register indexes and register reset values
// ----------------------------------------------------------------------------
package crc8fa_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DelayW = 16;

  // configuration register indexes
  localparam logic CfgIdxPoly = 1'b0;
  localparam logic CfgIdxInit = 1'b1;

  // register reset values
  localparam logic [ByteW-1:0] PolyReset = 8'hD9;
  localparam logic [ByteW-1:0] InitReset = 8'h00;

  // one transmit byte with its side information
  typedef struct packed {
    logic [ByteW-1:0]  tx_byte;
    logic [DelayW-1:0] tx_delay;
    logic              is_crc;
    logic              frame_end;
    logic              overlong;
  } tx_result_t;

endpackage

// ----- rtl/crc8fa_crc_unit.sv -----
// ----------------------------------------------------------------------------
// crc8fa_crc_unit: one byte of reflected crc-8
// eight lsb-first shift steps, unrolled, purely combinational
// ----------------------------------------------------------------------------
module crc8fa_crc_unit (
  input  logic [crc8fa_pkg::ByteW-1:0] crc_i,
  input  logic [crc8fa_pkg::ByteW-1:0] data_i,
  input  logic [crc8fa_pkg::ByteW-1:0] poly_i,
  output logic [crc8fa_pkg::ByteW-1:0] crc_o
);

  always_comb begin
    logic [crc8fa_pkg::ByteW-1:0] crc;
    crc = crc_i;
    for (int k = 0; k < crc8fa_pkg::ByteW; k++) begin
      if (crc[0] ^ data_i[k]) begin
        crc = (crc >> 1) ^ poly_i;
      end else begin
        crc = crc >> 1;
      end
    end
    crc_o = crc;
  end

endmodule

// ----- rtl/crc8fa_out_stage.sv -----
// ----------------------------------------------------------------------------
// crc8fa_out_stage: result register with a pending crc slot
// shows the payload byte first, then the crc byte that trails it
// ----------------------------------------------------------------------------
module crc8fa_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  crc8fa_pkg::tx_result_t        load_res_i,
  input  logic                          crc_load_i,
  input  logic [crc8fa_pkg::ByteW-1:0]  crc_byte_i,
  output logic                          can_load_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output crc8fa_pkg::tx_result_t        out_res_o
);

  logic                         out_valid_q, out_valid_d;
  logic                         pend_valid_q, pend_valid_d;
  crc8fa_pkg::tx_result_t       out_res_q, out_res_d;
  logic [crc8fa_pkg::ByteW-1:0] pend_byte_q, pend_byte_d;
  crc8fa_pkg::tx_result_t       crc_res;
  logic                         pop;

  assign pop        = out_valid_q && !out_stall_i;
  assign can_load_o = !pend_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    crc_res           = '0;
    crc_res.tx_byte   = pend_byte_q;
    crc_res.is_crc    = 1'b1;
    crc_res.frame_end = 1'b1;
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    out_res_d    = out_res_q;
    pend_byte_d  = pend_byte_q;
    priority if (load_i) begin
      out_valid_d  = 1'b1;
      out_res_d    = load_res_i;
      pend_valid_d = crc_load_i;
      pend_byte_d  = crc_byte_i;
    end else if (pop) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_res_d    = crc_res;
        pend_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q   <= out_res_d;
    pend_byte_q <= pend_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !pend_valid_q && (!out_valid_q || !out_stall_i))
    else $error("load while result slots full");
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending crc without payload ahead of it");
  a_crc_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && pend_valid_q |=> out_valid_q && out_res_q.is_crc && out_res_q.frame_end)
    else $error("crc byte did not follow its payload byte");
`endif

endmodule

// ----- rtl/crc8_frame_appender_core.sv -----
// an accepted request passes the input register, then the output register, onto the output
// throughput: one request per cycle unless out_stall is set; a pending crc byte stalls input
// output, one byte per cycle unless stalled, sets the rate; the crc is one unrolled byte step
// reset: async active low, clears the pipeline, packet state, crc_poly to 0xD9, crc_init to 0
// ----------------------------------------------------------------------------
// crc8_frame_appender_core: transmit framer with trailing reflected crc-8
// passes packet bytes through, puts the start delay on the first byte, flags bytes
// past the length limit and, if crc_poly != 0, appends the crc byte after the last byte
// ----------------------------------------------------------------------------
module crc8_frame_appender_core #(
  parameter int unsigned MAX_PACKET_BYTES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [crc8fa_pkg::ByteW-1:0]   data_byte_i,
  input  logic                           end_of_packet_i,
  input  logic [crc8fa_pkg::DelayW-1:0]  start_delay_i,
  // output requests
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [crc8fa_pkg::ByteW-1:0]   tx_byte_o,
  output logic [crc8fa_pkg::DelayW-1:0]  tx_delay_o,
  output logic                           is_crc_o,
  output logic                           frame_end_o,
  output logic                           overlong_o,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [crc8fa_pkg::ByteW-1:0]   cfg_data_i
);

  // byte counter saturates at MAX_PACKET_BYTES-1, one slot is left for the crc
  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES);
  localparam logic [CntW-1:0] Limit = CntW'(MAX_PACKET_BYTES - 1);

  // configuration registers
  logic [crc8fa_pkg::ByteW-1:0] crc_poly_q, crc_init_q;

  // input register
  logic                          s1_valid_q, s1_valid_d;
  logic [crc8fa_pkg::ByteW-1:0]  s1_byte_q;
  logic                          s1_last_q;
  logic [crc8fa_pkg::DelayW-1:0] s1_delay_q;

  // packet state
  logic [crc8fa_pkg::ByteW-1:0]  crc_acc_q, crc_acc_d;
  logic                          mid_packet_q, mid_packet_d;
  logic [CntW-1:0]               byte_count_q, byte_count_d;

  logic                          in_accept;
  logic                          advance;
  logic                          can_load;
  logic [crc8fa_pkg::ByteW-1:0]  crc_start;
  logic [crc8fa_pkg::ByteW-1:0]  crc_next;
  logic [CntW-1:0]               count_cur;
  logic                          over;
  logic                          with_crc;
  crc8fa_pkg::tx_result_t        payload_res;
  crc8fa_pkg::tx_result_t        out_res;

  // writes are always taken; only legal while the block is idle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_poly_q <= crc8fa_pkg::PolyReset;
      crc_init_q <= crc8fa_pkg::InitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        crc8fa_pkg::CfgIdxPoly: crc_poly_q <= cfg_data_i;
        crc8fa_pkg::CfgIdxInit: crc_init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register: holds one request while the output side is full
  assign in_accept  = in_valid_i && !in_stall_o;
  assign advance    = s1_valid_q && can_load;
  assign in_stall_o = s1_valid_q && !can_load;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q  <= data_byte_i;
      s1_last_q  <= end_of_packet_i;
      s1_delay_q <= start_delay_i;
    end
  end

  // packet start reloads the crc and clears the count
  assign crc_start = mid_packet_q ? crc_acc_q : crc_init_q;
  assign count_cur = mid_packet_q ? byte_count_q : '0;
  assign over      = count_cur >= Limit;
  assign with_crc  = s1_last_q && (crc_poly_q != '0);

  crc8fa_crc_unit u_crc (
    .crc_i  (crc_start),
    .data_i (s1_byte_q),
    .poly_i (crc_poly_q),
    .crc_o  (crc_next)
  );

  always_comb begin
    crc_acc_d    = crc_acc_q;
    mid_packet_d = mid_packet_q;
    byte_count_d = byte_count_q;
    if (advance) begin
      crc_acc_d    = crc_next;
      mid_packet_d = !s1_last_q;
      byte_count_d = over ? count_cur : count_cur + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_acc_q    <= '0;
      mid_packet_q <= 1'b0;
      byte_count_q <= '0;
    end else begin
      crc_acc_q    <= crc_acc_d;
      mid_packet_q <= mid_packet_d;
      byte_count_q <= byte_count_d;
    end
  end

  // payload byte: delay only on the first byte, frame end here when no crc
  always_comb begin
    payload_res           = '0;
    payload_res.tx_byte   = s1_byte_q;
    payload_res.tx_delay  = mid_packet_q ? '0 : s1_delay_q;
    payload_res.frame_end = s1_last_q && !with_crc;
    payload_res.overlong  = over;
  end

  crc8fa_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .load_res_i  (payload_res),
    .crc_load_i  (with_crc),
    .crc_byte_i  (crc_next),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res)
  );

  assign tx_byte_o   = out_res.tx_byte;
  assign tx_delay_o  = out_res.tx_delay;
  assign is_crc_o    = out_res.is_crc;
  assign frame_end_o = out_res.frame_end;
  assign overlong_o  = out_res.overlong;

`ifndef SYNTHESIS
  a_crc_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_crc_o |-> frame_end_o && (tx_delay_o == '0) && !overlong_o)
    else $error("crc byte with bad side fields");
  a_packet_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_last_q |=> !mid_packet_q)
    else $error("packet state not closed after last byte");
  a_payload_before_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && with_crc |=> out_valid_o && !is_crc_o && !frame_end_o)
    else $error("payload byte of a crc frame shown wrongly");
`endif

endmodule

// ----- bench/tb_crc8_frame_appender_core.sv -----
// ----------------------------------------------------------------------------
// tb_crc8_frame_appender_core: self-checking bench of the crc-8 frame appender
// drives packet byte requests with random bursts and gaps, stalls the output
// side on its own pattern, and checks every output byte against a predictor
// that tracks crc, packet position and register values of its own
// ----------------------------------------------------------------------------
module tb_crc8_frame_appender_core;

  // packet length limit of the instance, crc byte included
  localparam int MaxBytes   = 32;
  // generous bound on the whole run, far above the slowest legal schedule
  localparam int CycleLimit = 400000;

  // receiver stall patterns
  localparam int StallNone    = 0;
  localparam int StallLight   = 1;
  localparam int StallHeavy   = 2;
  localparam int StallPattern = 3;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input request channel
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [crc8fa_pkg::ByteW-1:0]  data_byte     = '0;
  logic                          end_of_packet = 1'b0;
  logic [crc8fa_pkg::DelayW-1:0] start_delay   = '0;

  // output request channel
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [crc8fa_pkg::ByteW-1:0]  tx_byte;
  logic [crc8fa_pkg::DelayW-1:0] tx_delay;
  logic                          is_crc;
  logic                          frame_end;
  logic                          overlong;

  // register write channel
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_index     = crc8fa_pkg::CfgIdxPoly;
  logic [crc8fa_pkg::ByteW-1:0]  cfg_data      = '0;

  // predictor state: registers and packet tracking
  logic [crc8fa_pkg::ByteW-1:0]  poly_reg  = crc8fa_pkg::PolyReset;
  logic [crc8fa_pkg::ByteW-1:0]  init_reg  = crc8fa_pkg::InitReset;
  logic [crc8fa_pkg::ByteW-1:0]  crc_run   = '0;
  logic                          in_packet = 1'b0;
  logic [5:0]                    pkt_count = '0;

  // output bytes still owed by the block, oldest first
  crc8fa_pkg::tx_result_t tx_expected[$];

  // sender burst shaping and receiver stall control
  int gap_max    = 0;
  int burst_left = 0;
  int stall_mode = StallNone;
  int hold_len   = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int rx_tick    = 0;

  // bookkeeping
  int cycle_count  = 0;
  int mismatches   = 0;
  int items_sent   = 0;
  int frames_done  = 0;
  int results_seen = 0;
  int crc_seen     = 0;
  int over_seen    = 0;
  int stall_seen   = 0;

  crc8_frame_appender_core #(
    .MAX_PACKET_BYTES(MaxBytes)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .end_of_packet_i(end_of_packet),
    .start_delay_i  (start_delay),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tx_byte_o      (tx_byte),
    .tx_delay_o     (tx_delay),
    .is_crc_o       (is_crc),
    .frame_end_o    (frame_end),
    .overlong_o     (overlong),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // 12 unit clock period
  always #6 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d output bytes still owed",
               cycle_count, tx_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // one byte of reflected crc-8, lsb first
  function automatic logic [crc8fa_pkg::ByteW-1:0] crc8_reflect_step(
    input logic [crc8fa_pkg::ByteW-1:0] acc,
    input logic [crc8fa_pkg::ByteW-1:0] data,
    input logic [crc8fa_pkg::ByteW-1:0] poly);
    logic [crc8fa_pkg::ByteW-1:0] c;
    int k;
    c = acc;
    for (k = 0; k < 8; k++) begin
      if (c[0] ^ data[k]) c = (c >> 1) ^ poly;
      else c = c >> 1;
    end
    return c;
  endfunction

  // queue the output bytes that one accepted payload byte causes
  function automatic void predict_tx_bytes(input logic [crc8fa_pkg::ByteW-1:0] data,
                                           input logic eop,
                                           input logic [crc8fa_pkg::DelayW-1:0] dly);
    crc8fa_pkg::tx_result_t        pay;
    crc8fa_pkg::tx_result_t        trail;
    logic [crc8fa_pkg::DelayW-1:0] this_dly;
    logic                          over;
    logic                          with_crc;
    this_dly = '0;
    // packet start: reload crc, restart count, take the delay
    if (!in_packet) begin
      crc_run   = init_reg;
      pkt_count = '0;
      this_dly  = dly;
      in_packet = 1'b1;
    end
    // one slot kept for the crc, count saturates at the limit
    over = int'(pkt_count) >= MaxBytes - 1;
    if (!over) pkt_count = pkt_count + 6'd1;
    crc_run  = crc8_reflect_step(crc_run, data, poly_reg);
    with_crc = eop && (poly_reg != '0);
    pay.tx_byte   = data;
    pay.tx_delay  = this_dly;
    pay.is_crc    = 1'b0;
    pay.frame_end = eop && !with_crc;
    pay.overlong  = over;
    tx_expected.push_back(pay);
    if (with_crc) begin
      trail.tx_byte   = crc_run;
      trail.tx_delay  = '0;
      trail.is_crc    = 1'b1;
      trail.frame_end = 1'b1;
      trail.overlong  = 1'b0;
      tx_expected.push_back(trail);
    end
    if (eop) in_packet = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // output check, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    crc8fa_pkg::tx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (is_crc) crc_seen++;
      if (overlong) over_seen++;
      if (tx_expected.size() == 0) begin
        // nothing owed, so the block made up a byte
        mismatches++;
        if (mismatches <= 10)
          $display("cycle %0d: unexpected output byte %02h delay %04h crc %0b end %0b over %0b",
                   cycle_count, tx_byte, tx_delay, is_crc, frame_end, overlong);
      end else begin
        want = tx_expected.pop_front();
        if (tx_byte !== want.tx_byte || tx_delay !== want.tx_delay ||
            is_crc !== want.is_crc || frame_end !== want.frame_end ||
            overlong !== want.overlong) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"cycle %0d: mismatch (expected/actual) byte %02h/%02h ",
                      "delay %04h/%04h crc %0b/%0b end %0b/%0b over %0b/%0b"},
                     cycle_count, want.tx_byte, tx_byte, want.tx_delay, tx_delay,
                     want.is_crc, is_crc, want.frame_end, frame_end,
                     want.overlong, overlong);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: long hold-off on request, otherwise the current stall pattern
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (hold_req != hold_seen) begin
      // start of a long hold-off, counted down here
      hold_seen <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        StallLight:   out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy:   out_stall <= ($urandom_range(0, 9) < 6);
        StallPattern: out_stall <= ((rx_tick % 7) < 3);
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender helpers; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------

  // offer one payload byte and hold it until taken
  task automatic send_byte(input logic [crc8fa_pkg::ByteW-1:0] data, input logic eop,
                           input logic [crc8fa_pkg::DelayW-1:0] dly);
    in_valid      = 1'b1;
    data_byte     = data;
    end_of_packet = eop;
    start_delay   = dly;
    do begin
      @(posedge clk);
      if (in_stall) stall_seen++;
    end while (in_stall);
    predict_tx_bytes(data, eop, dly);
    items_sent++;
    @(negedge clk);
  endtask

  // random gap at the end of a burst
  task automatic idle_between();
    int n;
    if (gap_max == 0) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 12);
    n          = $urandom_range(1, gap_max);
    in_valid   = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // stop offering and let every owed byte come out
  task automatic wait_drain();
    in_valid = 1'b0;
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(input logic idx, input logic [crc8fa_pkg::ByteW-1:0] value);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (idx == crc8fa_pkg::CfgIdxPoly) poly_reg = value;
    else init_reg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // start delay with its extremes weighted in
  function automatic logic [crc8fa_pkg::DelayW-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return crc8fa_pkg::DelayW'($urandom_range(0, 65535));
  endfunction

  // whole packet of random bytes; later bytes carry random delays to be dropped
  task automatic send_packet(input int len, input logic [crc8fa_pkg::DelayW-1:0] first_dly);
    int k;
    for (k = 0; k < len; k++) begin
      send_byte(crc8fa_pkg::ByteW'($urandom_range(0, 255)), k == len - 1,
                (k == 0) ? first_dly : crc8fa_pkg::DelayW'($urandom_range(0, 65535)));
      idle_between();
    end
    frames_done++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, single-byte packets, delay only on the first byte, crc off
  task automatic test_edge_values();
    gap_max    = 0;
    stall_mode = StallNone;
    // reset polynomial and start value
    send_byte(8'h00, 1'b1, 16'hFFFF);
    send_byte(8'hFF, 1'b0, 16'h0000);
    send_byte(8'h80, 1'b0, 16'hFFFF);
    send_byte(8'h01, 1'b1, 16'hAAAA);
    // crc disabled, payload byte ends the frame
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h00);
    send_byte(8'hA5, 1'b1, 16'h5555);
    send_byte(8'h5A, 1'b0, 16'h0001);
    send_byte(8'hC3, 1'b1, 16'h8000);
    // all-ones registers
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'hFF);
    write_reg(crc8fa_pkg::CfgIdxInit, 8'hFF);
    send_byte(8'hFF, 1'b0, 16'h00FF);
    send_byte(8'h00, 1'b1, 16'hFF00);
    // smallest nonzero polynomial
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h01);
    write_reg(crc8fa_pkg::CfgIdxInit, 8'h00);
    send_byte(8'h7E, 1'b1, 16'h0000);
    wait_drain();
  endtask

  // register writes between bytes of an open packet
  task automatic test_config_mid_packet();
    gap_max    = 0;
    stall_mode = StallNone;
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h8C);
    send_byte(8'h31, 1'b0, 16'h0123);
    // new polynomial applies from the next byte on
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'hE0);
    send_byte(8'h32, 1'b0, 16'h4567);
    // new start value waits for the next packet
    write_reg(crc8fa_pkg::CfgIdxInit, 8'h5A);
    send_byte(8'h33, 1'b1, 16'h89AB);
    send_byte(8'h34, 1'b1, 16'hCDEF);
    // crc switched off before the last byte of a packet
    send_byte(8'h35, 1'b0, 16'h0042);
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h00);
    send_byte(8'h36, 1'b1, 16'h0000);
    wait_drain();
  endtask

  // packets around and past the length limit, with crc on and off
  task automatic test_overlong_packets();
    gap_max    = 2;
    stall_mode = StallLight;
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h8C);
    write_reg(crc8fa_pkg::CfgIdxInit, 8'h00);
    send_packet(MaxBytes - 2, pick_delay());
    send_packet(MaxBytes - 1, pick_delay());
    send_packet(MaxBytes, pick_delay());
    send_packet(MaxBytes + 8, pick_delay());
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'h00);
    send_packet(MaxBytes + 2, pick_delay());
    wait_drain();
  endtask

  // long output hold-off while input keeps coming, then a full drain
  task automatic test_output_backpressure();
    gap_max    = 0;
    stall_mode = StallNone;
    write_reg(crc8fa_pkg::CfgIdxPoly, 8'hD9);
    hold_len = 150;
    hold_req++;
    repeat (4) send_packet(12, pick_delay());
    wait_drain();
  endtask

  // random packets under one register setting and traffic shape
  task automatic test_random_traffic(input logic [crc8fa_pkg::ByteW-1:0] poly,
                                     input logic [crc8fa_pkg::ByteW-1:0] init,
                                     input int n_items, input int gaps, input int stall_pat);
    int target;
    int len;
    int r;
    write_reg(crc8fa_pkg::CfgIdxPoly, poly);
    write_reg(crc8fa_pkg::CfgIdxInit, init);
    gap_max    = gaps;
    stall_mode = stall_pat;
    burst_left = 0;
    target     = items_sent + n_items;
    while (items_sent < target) begin
      // mostly short packets, many single bytes, now and then one around or past the limit
      r = $urandom_range(0, 19);
      if (r == 0) len = $urandom_range(MaxBytes - 2, MaxBytes + 8);
      else if (r < 5) len = 1;
      else len = $urandom_range(2, 12);
      send_packet(len, pick_delay());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    // reset asserted at the start, released at a falling edge
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_edge_values();
    test_config_mid_packet();
    test_overlong_packets();
    test_output_backpressure();
    test_random_traffic(crc8fa_pkg::PolyReset, crc8fa_pkg::InitReset, 260, 4, StallLight);
    test_random_traffic(8'h00, 8'hFF, 250, 0, StallNone);
    test_random_traffic(8'hFF, 8'hFF, 250, 8, StallHeavy);
    test_random_traffic(8'h01, 8'h00, 250, 3, StallPattern);
    test_random_traffic(crc8fa_pkg::ByteW'($urandom_range(1, 255)),
                        crc8fa_pkg::ByteW'($urandom_range(0, 255)),
                        250, 5, StallLight);
    test_random_traffic(crc8fa_pkg::ByteW'($urandom_range(0, 255)),
                        crc8fa_pkg::ByteW'($urandom_range(0, 255)),
                        250, 2, StallHeavy);

    // final drain, then idle time with the receiver stall off
    wait_drain();
    stall_mode = StallNone;
    repeat (10) @(negedge clk);
    if (tx_expected.size() != 0) begin
      mismatches++;
      $display("%0d output bytes never arrived", tx_expected.size());
    end

    $display("run: %0d payload bytes in %0d packets, %0d output bytes checked",
             items_sent, frames_done, results_seen);
    $display("     %0d crc bytes, %0d overlong bytes, input held %0d cycles, %0d mismatches",
             crc_seen, over_seen, stall_seen, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- crc8_frame_appender_core.f -----
rtl/crc8fa_pkg.sv
rtl/crc8fa_crc_unit.sv
rtl/crc8fa_out_stage.sv
rtl/crc8_frame_appender_core.sv
bench/tb_crc8_frame_appender_core.sv
